@@ rtl/cfpp_pkg.sv @@
// Shared constants, types and the CRC step for the framed packet parser.
`timescale 1ns / 1ps
`default_nettype none

package cfpp_pkg;

    // Frame geometry
    localparam int MAX_PAYLOAD = 64;
    localparam int STORE_DEPTH = MAX_PAYLOAD + 2;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Fixed field widths
    localparam int BYTE_W  = 8;
    localparam int PLEN_W  = 7;
    localparam int IDX_W   = 6;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND = 8'd1;
    localparam logic [7:0] MAGIC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] MAGIC_SECOND_RST = 8'h55;

    // CRC16-CCITT
    localparam logic [15:0] CRC_START = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // Body store write port
    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [BYTE_W-1:0]   data;
    } t_ram_wr;

    // Hand-over of a good frame to the drain side
    typedef struct packed {
        logic              valid;
        logic [PLEN_W-1:0] plen;
    } t_frame_start;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] seq;
        logic [BYTE_W-1:0] cmd;
        logic [PLEN_W-1:0] plen;
        logic              has_payload;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_result;

    // One byte through the CRC, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cfpp_body_ram.sv @@
// Body store: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cfpp_body_ram
    import cfpp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_ram_wr             i_wr,
    input  wire logic                i_rd_en,
    input  wire logic [STORE_AW-1:0] i_rd_addr,
    output logic [BYTE_W-1:0]        o_rd_data
);

    logic [BYTE_W-1:0] r_mem [STORE_DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/cfpp_rx.sv @@
// Receive side: frame hunt, length check, running CRC and body store writes.
`timescale 1ns / 1ps
`default_nettype none

module cfpp_rx
    import cfpp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [BYTE_W-1:0] i_magic_first,
    input  wire logic [BYTE_W-1:0] i_magic_second,
    output t_ram_wr                o_wr,
    output t_frame_start           o_start
);

    typedef enum logic [2:0] {
        PH_MAGIC_A = 3'd0,
        PH_MAGIC_B = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_BODY    = 3'd4,
        PH_CRC_HI  = 3'd5,
        PH_CRC_LO  = 3'd6
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [15:0]       r_crc, n_crc;
    logic [BYTE_W-1:0] r_len_hi, n_len_hi;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_crc_hi, n_crc_hi;

    logic [15:0]       crc_next;
    logic [15:0]       crc_first;
    logic [15:0]       len_word;
    logic [CNT_W-1:0]  count_inc;

    assign crc_next  = crc16_step(r_crc, i_byte);
    assign crc_first = crc16_step(CRC_START, i_byte);
    assign len_word  = {r_len_hi, i_byte};
    assign count_inc = r_count + CNT_W'(1);

    // Next-state logic, one received byte per transaction
    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_len_hi = r_len_hi;
        n_len    = r_len;
        n_count  = r_count;
        n_crc_hi = r_crc_hi;
        o_wr     = '{en: 1'b0, addr: r_count[STORE_AW-1:0], data: i_byte};
        o_start  = '{valid: 1'b0, plen: PLEN_W'(r_len - CNT_W'(2))};
        if (i_take) begin
            case (r_phase)
                PH_MAGIC_B: begin
                    if (i_byte == i_magic_second) begin
                        n_crc   = crc_next;
                        n_phase = PH_LEN_HI;
                    end else if (i_byte == i_magic_first) begin
                        // retry the byte as a first start byte
                        n_crc   = crc_first;
                        n_phase = PH_MAGIC_B;
                    end else begin
                        n_crc   = CRC_START;
                        n_phase = PH_MAGIC_A;
                    end
                end
                PH_LEN_HI: begin
                    n_crc    = crc_next;
                    n_len_hi = i_byte;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (len_word < 16'd2 || len_word > 16'(STORE_DEPTH)) begin
                        n_crc   = CRC_START;
                        n_phase = PH_MAGIC_A;
                    end else begin
                        n_crc   = crc_next;
                        n_len   = len_word[CNT_W-1:0];
                        n_count = '0;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_crc   = crc_next;
                    o_wr.en = 1'b1;
                    n_count = count_inc;
                    if (count_inc >= r_len) begin
                        n_phase = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    n_crc_hi = i_byte;
                    n_phase  = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    o_start.valid = ({r_crc_hi, i_byte} == r_crc);
                    n_crc         = CRC_START;
                    n_phase       = PH_MAGIC_A;
                end
                default: begin
                    // hunting, and the unused phase code
                    n_phase = PH_MAGIC_A;
                    if (i_byte == i_magic_first) begin
                        n_crc   = crc_first;
                        n_phase = PH_MAGIC_B;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC_A;
            r_crc    <= CRC_START;
            r_len_hi <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_crc_hi <= '0;
        end else begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_len_hi <= n_len_hi;
            r_len    <= n_len;
            r_count  <= n_count;
            r_crc_hi <= n_crc_hi;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cfpp_tx.sv @@
// Drain side: reads a good frame back from the body store into the output register.
`timescale 1ns / 1ps
`default_nettype none

module cfpp_tx
    import cfpp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_frame_start        i_start,
    input  wire logic                i_out_take,
    input  wire logic [BYTE_W-1:0]   i_rd_data,
    output logic                     o_rd_en,
    output logic [STORE_AW-1:0]      o_rd_addr,
    output logic                     o_busy,
    output logic                     o_valid,
    output t_result                  o_result
);

    logic              r_busy, n_busy;
    logic              r_pend, n_pend;
    logic [CNT_W-1:0]  r_addr, n_addr;
    logic [CNT_W-1:0]  r_pend_addr, n_pend_addr;
    logic [PLEN_W-1:0] r_plen, n_plen;
    logic [BYTE_W-1:0] r_seq, n_seq;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic              r_valid, n_valid;
    t_result           r_result, n_result;

    logic              out_free;
    logic              issue;
    logic [CNT_W-1:0]  last_addr;

    assign out_free  = !r_valid || i_out_take;
    // header bytes sit at 0 and 1; the last read is 1 for an empty payload
    assign issue     = r_busy && !r_pend && (r_addr == '0 || out_free);
    assign last_addr = (r_plen == '0) ? CNT_W'(1) : CNT_W'(r_plen) + CNT_W'(1);

    assign o_rd_en   = issue;
    assign o_rd_addr = r_addr[STORE_AW-1:0];
    assign o_busy    = r_busy;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    // Read issue, return and output register load
    always_comb begin
        n_busy      = r_busy;
        n_pend      = issue;
        n_addr      = r_addr;
        n_pend_addr = r_pend_addr;
        n_plen      = r_plen;
        n_seq       = r_seq;
        n_cmd       = r_cmd;
        n_valid     = r_valid && !i_out_take;
        n_result    = r_result;

        if (issue) begin
            n_addr      = r_addr + CNT_W'(1);
            n_pend_addr = r_addr;
        end

        if (r_pend) begin
            if (r_pend_addr == '0) begin
                n_seq = i_rd_data;
            end else if (r_pend_addr == CNT_W'(1)) begin
                n_cmd = i_rd_data;
                if (r_plen == '0) begin
                    // empty payload: a single result with no data
                    n_result = '{seq: r_seq, cmd: i_rd_data, plen: '0, has_payload: 1'b0,
                                 idx: '0, data: '0, last: 1'b1};
                    n_valid  = 1'b1;
                    n_busy   = 1'b0;
                end
            end else begin
                n_result = '{seq: r_seq, cmd: r_cmd, plen: r_plen, has_payload: 1'b1,
                             idx: IDX_W'(r_pend_addr - CNT_W'(2)), data: i_rd_data,
                             last: (r_pend_addr == last_addr)};
                n_valid  = 1'b1;
                if (r_pend_addr == last_addr) begin
                    n_busy = 1'b0;
                end
            end
        end

        if (i_start.valid) begin
            n_busy = 1'b1;
            n_addr = '0;
            n_plen = i_start.plen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pend  <= 1'b0;
            r_addr  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_pend  <= n_pend;
            r_addr  <= n_addr;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_plen      <= n_plen;
        r_seq       <= n_seq;
        r_cmd       <= n_cmd;
        r_result    <= n_result;
    end

endmodule

`default_nettype wire

@@ rtl/crc_framed_packet_parser_top.sv @@
// Top level of the magic/length/CRC16 framed packet parser.
//
//  Channel   Dir  Handshake                   Contents
//  s_axis    in   s_axis_tvalid/tready        tdata[7:0] rx_byte
//  m_axis    out  m_axis_tvalid/tready        tdata: seq, cmd, len, index, byte;
//                                             tuser has_payload; tlast last
//  cfg       in   i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// Receive side takes one byte per cycle while no frame is being drained.
// A good frame is read back from the body store one result at a time, with one store
// read in flight at a time; the two header bytes are read first.
// s_axis_tready is low from the cycle after a good frame's final CRC byte until its
// last result is in the output register; a stalled m_axis holds the drain.
// Reset is synchronous, active low, and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module crc_framed_packet_parser_top
    import cfpp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [7:0] frame_seq, [15:8] frame_cmd, [22:16] data_len,
    // [28:23] byte_index, [36:29] payload_byte, [39:37] zero
    output logic [39:0]               m_axis_tdata,
    output logic                      m_axis_tuser,   // [0] has_payload
    output logic                      m_axis_tlast,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    logic [7:0]          r_magic_first;
    logic [7:0]          r_magic_second;
    logic                in_take;
    logic                out_take;
    t_ram_wr             w_wr;
    t_frame_start        w_start;
    logic                w_rd_en;
    logic [STORE_AW-1:0] w_rd_addr;
    logic [BYTE_W-1:0]   w_rd_data;
    logic                w_busy;
    t_result             w_result;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_first  <= MAGIC_FIRST_RST;
            r_magic_second <= MAGIC_SECOND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAGIC_FIRST:  r_magic_first  <= i_cfg_data;
                REG_MAGIC_SECOND: r_magic_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshakes
    assign s_axis_tready = !w_busy;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_take      = m_axis_tvalid && m_axis_tready;

    cfpp_rx u_rx (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (in_take),
        .i_byte         (s_axis_tdata),
        .i_magic_first  (r_magic_first),
        .i_magic_second (r_magic_second),
        .o_wr           (w_wr),
        .o_start        (w_start)
    );

    cfpp_body_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    cfpp_tx u_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_take (out_take),
        .i_rd_data  (w_rd_data),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .o_busy     (w_busy),
        .o_valid    (m_axis_tvalid),
        .o_result   (w_result)
    );

    // Output packing
    assign m_axis_tdata = {3'b000, w_result.data, w_result.idx, w_result.plen,
                           w_result.cmd, w_result.seq};
    assign m_axis_tuser = w_result.has_payload;
    assign m_axis_tlast = w_result.last;

`ifndef SYNTH
    // an empty-payload result is always the end of its frame
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty-payload result without tlast");

    // payload index stays inside the payload
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            PLEN_W'(m_axis_tdata[28:23]) < m_axis_tdata[22:16])
        else $error("byte_index beyond data_len");

    // the final payload result carries the last index
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser && m_axis_tlast |->
            PLEN_W'(m_axis_tdata[28:23]) == m_axis_tdata[22:16] - PLEN_W'(1))
        else $error("tlast on wrong byte_index");

    // body store is never written while a frame drains from it
    a_no_wr_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_wr.en)
        else $error("body store written during drain");

    // a good frame starts the drain on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start.valid |=> w_busy)
        else $error("drain did not start");
`endif

endmodule

`default_nettype wire

@@ tb/crc_framed_packet_parser_top_tb.sv @@
// Self-checking testbench for the magic/length/CRC16 framed packet parser.
`timescale 1ns / 1ps
`default_nettype none

module crc_framed_packet_parser_top_tb;
    import cfpp_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 9;
    localparam int IDLE_LIMIT  = 5000;  // cycles with no transaction at all
    localparam int LONG_HOLD   = 400;   // one long sink stall to back up the input
    localparam int DRAIN_SLACK = 20;
    localparam int RAND_BYTES  = 2;     // random bytes per register setting
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;

    typedef enum logic [2:0] {
        HUNT_FIRST, HUNT_SECOND, LEN_HIGH, LEN_LOW, BODY, CRC_HIGH, CRC_LOW
    } t_parse_state;

    typedef enum int {GOOD, BAD_CRC, BAD_LEN, BAD_SECOND, NOISE} t_frame_kind;

    // CRC16-CCITT, one byte, bit-serial MSB first
    function automatic logic [15:0] ccitt_next(logic [15:0] crc, logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    // Parser model plus the queue of results still owed by the block
    class frame_checker;
        logic [7:0]   magic_first;
        logic [7:0]   magic_second;
        t_parse_state state;
        logic [15:0]  len_word;
        int           body_cnt;
        logic [7:0]   body [STORE_DEPTH];
        logic [7:0]   crc_hi;
        logic [15:0]  crc;
        t_result      pending_results[$];
        int           n_err;

        function new();
            magic_first  = MAGIC_FIRST_RST;
            magic_second = MAGIC_SECOND_RST;
            state        = HUNT_FIRST;
            len_word     = '0;
            body_cnt     = 0;
            crc_hi       = '0;
            crc          = CRC_START;
            n_err        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                REG_MAGIC_FIRST:  magic_first  = val;
                REG_MAGIC_SECOND: magic_second = val;
                default: ;
            endcase
        endfunction

        function void restart();
            state = HUNT_FIRST;
            crc   = CRC_START;
        endfunction

        function void try_first(logic [7:0] b);
            if (b == magic_first) begin
                crc   = ccitt_next(CRC_START, b);
                state = HUNT_SECOND;
            end
        endfunction

        // good frame: one result per payload byte, or a single empty one
        function void queue_frame_results();
            int      plen;
            t_result r;
            plen          = int'(len_word) - 2;
            r.seq         = body[0];
            r.cmd         = body[1];
            r.plen        = 7'(plen);
            r.has_payload = (plen != 0);
            if (plen == 0) begin
                r.idx  = '0;
                r.data = '0;
                r.last = 1'b1;
                pending_results.push_back(r);
            end else begin
                for (int i = 0; i < plen; i++) begin
                    r.idx  = 6'(i);
                    r.data = body[2 + i];
                    r.last = (i == plen - 1);
                    pending_results.push_back(r);
                end
            end
        endfunction

        function void take_rx_byte(logic [7:0] b);
            case (state)
                HUNT_SECOND: begin
                    crc = ccitt_next(crc, b);
                    if (b == magic_second) begin
                        state = LEN_HIGH;
                    end else begin
                        // retry the same byte as a frame start
                        restart();
                        try_first(b);
                    end
                end
                LEN_HIGH: begin
                    crc      = ccitt_next(crc, b);
                    len_word = {b, 8'h00};
                    state    = LEN_LOW;
                end
                LEN_LOW: begin
                    crc           = ccitt_next(crc, b);
                    len_word[7:0] = b;
                    if (len_word < 2 || len_word > STORE_DEPTH) begin
                        restart();
                    end else begin
                        body_cnt = 0;
                        state    = BODY;
                    end
                end
                BODY: begin
                    crc            = ccitt_next(crc, b);
                    body[body_cnt] = b;
                    body_cnt++;
                    if (body_cnt >= len_word) state = CRC_HIGH;
                end
                CRC_HIGH: begin
                    crc_hi = b;
                    state  = CRC_LOW;
                end
                CRC_LOW: begin
                    if ({crc_hi, b} == crc) queue_frame_results();
                    restart();
                end
                default: try_first(b);
            endcase
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                n_err++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: extra result, expected none, got %h/%h/%0d/%0d/%h/%b",
                         $time, got.seq, got.cmd, got.plen, got.idx, got.data, got.last);
                n_err++;
                return;
            end
            want = pending_results.pop_front();
            field_check("frame_seq",    want.seq,         got.seq);
            field_check("frame_cmd",    want.cmd,         got.cmd);
            field_check("data_len",     want.plen,        got.plen);
            field_check("has_payload",  want.has_payload, got.has_payload);
            field_check("byte_index",   want.idx,         got.idx);
            field_check("payload_byte", want.data,        got.data);
            field_check("last",         want.last,        got.last);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [39:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    frame_checker sb;
    bit           hold_req    = 1'b0;
    int           idle_cycles = 0;

    crc_framed_packet_parser_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: ends the run after a long spell with no transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("crc_framed_packet_parser_top_tb: done, errors");
            $finish;
        end
    end

    // Result sink with random stalls and one long hold-off on request
    initial begin : result_sink
        int      stall;
        bit      burst;
        t_result got;
        burst = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) burst = !burst;
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                stall = burst ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.seq         = m_axis_tdata[7:0];
            got.cmd         = m_axis_tdata[15:8];
            got.plen        = m_axis_tdata[22:16];
            got.idx         = m_axis_tdata[28:23];
            got.data        = m_axis_tdata[36:29];
            got.has_payload = m_axis_tuser;
            got.last        = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // One byte on the input stream; valid stays up when there is no gap
    task automatic send_byte(input logic [7:0] b, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_rx_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] fb[$], input bit burst);
        foreach (fb[i]) send_byte(fb[i], burst);
    endtask

    // Append the big-endian CRC of fb[from:$], optionally spoiled
    function automatic void push_crc(ref logic [7:0] fb[$], input int from, input bit corrupt);
        logic [15:0] crc;
        crc = CRC_START;
        for (int i = from; i < fb.size(); i++) crc = ccitt_next(crc, fb[i]);
        if (corrupt) crc ^= 16'($urandom_range(1, 16'hFFFF));
        fb.push_back(crc[15:8]);
        fb.push_back(crc[7:0]);
    endfunction

    task automatic build_frame(input t_frame_kind kind, input int plen,
                               output logic [7:0] fb[$]);
        logic [15:0] len;
        logic [7:0]  wrong;
        int          start;
        fb = {};
        if (kind == NOISE) begin
            repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom_range(0, 255)));
            return;
        end
        // broken start: first magic, then anything but the second
        if (kind == BAD_SECOND) begin
            wrong = sb.magic_second ^ 8'($urandom_range(1, 255));
            if (sb.magic_first != sb.magic_second && $urandom_range(0, 1) == 1)
                wrong = sb.magic_first;
            fb.push_back(sb.magic_first);
            fb.push_back(wrong);
        end
        if (kind == BAD_LEN) begin
            case ($urandom_range(0, 3))
                0:       len = 16'h0000;
                1:       len = 16'h0001;
                2:       len = 16'(STORE_DEPTH + 1);
                default: len = 16'($urandom_range(STORE_DEPTH + 1, 16'hFFFF));
            endcase
        end else begin
            len = 16'(plen + 2);
        end
        start = fb.size();
        fb.push_back(sb.magic_first);
        fb.push_back(sb.magic_second);
        fb.push_back(len[15:8]);
        fb.push_back(len[7:0]);
        if (kind == BAD_LEN) return;
        repeat (plen + 2) fb.push_back(8'($urandom_range(0, 255)));
        push_crc(fb, start, kind == BAD_CRC);
    endtask

    // Mostly good frames, short payloads, the odd long one
    task automatic random_traffic(input int n_bytes);
        logic [7:0]  fb[$];
        int          sent;
        int          pick;
        int          plen;
        t_frame_kind kind;
        bit          burst;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)      kind = GOOD;
            else if (pick < 75) kind = BAD_CRC;
            else if (pick < 83) kind = BAD_LEN;
            else if (pick < 91) kind = BAD_SECOND;
            else                kind = NOISE;
            if ($urandom_range(0, 9) == 0) plen = $urandom_range(7, MAX_PAYLOAD);
            else                           plen = $urandom_range(0, 6);
            burst = ($urandom_range(0, 3) == 0);
            build_frame(kind, plen, fb);
            send_frame(fb, burst);
            sent += fb.size();
        end
    endtask

    // Wait for every owed result, then let the block fall quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // Both magic registers plus a write to an unused index
    task automatic set_magics(input logic [7:0] first, input logic [7:0] second);
        i_cfg_valid <= 1'b1;
        cfg_write(REG_MAGIC_FIRST, first);
        cfg_write(REG_MAGIC_SECOND, second);
        cfg_write(REG_SPARE, 8'($urandom_range(0, 255)));
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial begin : stimulus
        logic [7:0] fb[$];
        logic [7:0] v;
        int         start;
        sb = new();
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset magics: wrong second byte retried as a start, empty frame with
        // extreme seq/cmd, short and long length, CRC mismatch, one-byte payload
        fb = {MAGIC_FIRST_RST, MAGIC_FIRST_RST, MAGIC_SECOND_RST, 8'h00, 8'h02, 8'h00, 8'hFF};
        push_crc(fb, 1, 1'b0);
        fb = {fb, MAGIC_FIRST_RST, MAGIC_SECOND_RST, 8'h00, 8'h01};
        fb = {fb, MAGIC_FIRST_RST, MAGIC_SECOND_RST, 8'h00, 8'(STORE_DEPTH + 1)};
        start = fb.size();
        fb = {fb, MAGIC_FIRST_RST, MAGIC_SECOND_RST, 8'h00, 8'h03, 8'hFF, 8'h00, 8'h80};
        push_crc(fb, start, 1'b1);
        start = fb.size();
        fb = {fb, MAGIC_FIRST_RST, MAGIC_SECOND_RST, 8'h00, 8'h03, 8'hFF, 8'h00, 8'h80};
        push_crc(fb, start, 1'b0);
        send_frame(fb, 1'b0);
        settle();

        // all-zero first magic, all-one second; full payload under a long sink stall
        set_magics(8'h00, 8'hFF);
        random_traffic(RAND_BYTES / 2);
        build_frame(GOOD, MAX_PAYLOAD, fb);
        hold_req = 1'b1;
        send_frame(fb, 1'b1);
        random_traffic(RAND_BYTES / 2);
        settle();

        set_magics(8'hFF, 8'h00);
        random_traffic(RAND_BYTES);
        settle();

        // identical magic bytes
        v = 8'($urandom_range(0, 255));
        set_magics(v, v);
        random_traffic(RAND_BYTES);
        settle();

        set_magics(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_traffic(RAND_BYTES);
        settle();

        if (sb.n_err == 0) begin
            $display("crc_framed_packet_parser_top_tb: done, clean");
        end else begin
            $display("crc_framed_packet_parser_top_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ crc_framed_packet_parser_top.f @@
rtl/cfpp_pkg.sv
rtl/cfpp_body_ram.sv
rtl/cfpp_rx.sv
rtl/cfpp_tx.sv
rtl/crc_framed_packet_parser_top.sv
tb/crc_framed_packet_parser_top_tb.sv
